/* rtl/ccin_pkg.sv */
package ccin_pkg;

   localparam int COORD_WIDTH = 32;

   localparam int CW = COORD_WIDTH;
   localparam int RW = CW - 1;
   localparam int UW = CW + 1;
   localparam int SW = 2 * UW;
   localparam int AW = UW + 1;
   localparam int DW = UW + 1;
   localparam int NW = AW + UW;
   localparam int TW = AW + 3;

   typedef enum logic [1:0] {
      STATUS_FOUND      = 2'd0,
      STATUS_FAR        = 2'd1,
      STATUS_NESTED     = 2'd2,
      STATUS_CONCENTRIC = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [CW-1:0] first_center_x;
      logic signed [CW-1:0] first_center_y;
      logic [RW-1:0]        first_radius;
      logic signed [CW-1:0] second_center_x;
      logic signed [CW-1:0] second_center_y;
      logic [RW-1:0]        second_radius;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic signed [CW-1:0] point_one_x;
      logic signed [CW-1:0] point_one_y;
      logic signed [CW-1:0] point_two_x;
      logic signed [CW-1:0] point_two_y;
   } rsp_type;

endpackage

/* rtl/ccin_req_if.sv */
interface ccin_req_if;
   logic              valid;
   logic              ready;
   ccin_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/ccin_rsp_if.sv */
interface ccin_rsp_if;
   logic              valid;
   logic              ready;
   ccin_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/circle_circle_intersection_unit.sv */
// Two-circle intersection, fully pipelined: one circle pair per cycle unless
// a result waits untaken (33-bit square root and 34-bit divide chains, one
// result bit per stage, run twice each in series). Status 1 (too far), 2
// (nested) and 3 (concentric) return zero points. Coordinates are raw fixed
// point and saturate. A result not taken holds the whole pipeline.
module circle_circle_intersection_unit (
   input  logic  clock,
   input  logic  reset,
   ccin_req_if.sink   req_chan,
   ccin_rsp_if.source rsp_chan
);
   localparam int CW = ccin_pkg::CW;
   localparam int RW = ccin_pkg::RW;
   localparam int UW = ccin_pkg::UW;
   localparam int SW = ccin_pkg::SW;
   localparam int AW = ccin_pkg::AW;
   localparam int DW = ccin_pkg::DW;
   localparam int NW = ccin_pkg::NW;
   localparam int TW = ccin_pkg::TW;
   localparam int L1 = UW - 2;
   localparam int L2 = AW;
   localparam int L3 = UW;
   localparam int L4 = AW;

   localparam logic signed [TW-1:0] SAT_HI = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [TW-1:0] SAT_LO = {{(TW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   typedef struct packed {
      logic [UW-1:0] ux, uy;
      logic          xneg, yneg;
      logic [RW-1:0] r1, r2;
      logic [RW:0]   rsum;
      logic [RW-1:0] rdiff;
      logic [CW-1:0] c1x, c1y;
   } s2_type;

   typedef struct packed {
      logic [2*UW-1:0] uxsq, uysq;
      logic [2*RW-1:0] r1sq, r2sq, diffsq;
      logic [2*RW+1:0] sumsq;
      logic [UW-1:0]   ux, uy;
      logic            xneg, yneg;
      logic [CW-1:0]   c1x, c1y;
   } s3_type;

   typedef struct packed {
      logic [SW-1:0]   d2;
      logic [2*RW-1:0] r1sq, r2sq, diffsq;
      logic [2*RW+1:0] sumsq;
      logic [UW-1:0]   ux, uy;
      logic            xneg, yneg;
      logic [CW-1:0]   c1x, c1y;
   } s4_type;

   typedef struct packed {
      ccin_pkg::status_type status;
      logic [SW-1:0]        p;
      logic [2*RW-1:0]      r1sq, r2sq;
      logic [UW-1:0]        ux, uy;
      logic                 xneg, yneg;
      logic [CW-1:0]        c1x, c1y;
   } s5_type;

   typedef struct packed {
      ccin_pkg::status_type status;
      logic                 aneg;
      logic [SW-1:0]        num;
      logic [2*RW-1:0]      r1sq;
      logic [UW-1:0]        ux, uy;
      logic                 xneg, yneg;
      logic [CW-1:0]        c1x, c1y;
   } a_type;

   typedef struct packed {
      ccin_pkg::status_type status;
      logic                 aneg;
      logic [UW-1:0]        d;
      logic [2*RW-1:0]      r1sq;
      logic [UW-1:0]        ux, uy;
      logic                 xneg, yneg;
      logic [CW-1:0]        c1x, c1y;
   } b_type;

   typedef struct packed {
      b_type           b;
      logic [AW-1:0]   amag;
      logic [2*AW-1:0] hh;
   } t1_type;

   typedef struct packed {
      b_type         b;
      logic [AW-1:0] amag;
      logic [SW-1:0] rad;
   } t2_type;

   typedef struct packed {
      b_type         b;
      logic [AW-1:0] amag;
   } c_type;

   typedef struct packed {
      ccin_pkg::status_type status;
      logic                 aneg, xneg, yneg;
      logic [CW-1:0]        c1x, c1y;
   } e_type;

   typedef struct packed {
      e_type         e;
      logic [UW-1:0] d;
      logic [NW-1:0] pax, pay, phx, phy;
   } u_type;

   typedef struct packed {
      ccin_pkg::status_type status;
      logic signed [TW-1:0] p1x, p1y, p2x, p2y;
   } v_type;

   function automatic logic [CW-1:0] sat_coord(input logic signed [TW-1:0] v);
      logic [CW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[CW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[CW-1:0];
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   logic adv;
   assign adv            = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   // front stages
   ccin_pkg::req_type s1_ff;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   a_type  s6_ff, s6_in;
   logic   s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;

   logic signed [CW:0] vx, vy;

   assign vx = $signed({s1_ff.second_center_x[CW-1], s1_ff.second_center_x})
             - $signed({s1_ff.first_center_x[CW-1], s1_ff.first_center_x});
   assign vy = $signed({s1_ff.second_center_y[CW-1], s1_ff.second_center_y})
             - $signed({s1_ff.first_center_y[CW-1], s1_ff.first_center_y});

   always_comb begin
      s2_in.xneg  = vx[CW];
      s2_in.yneg  = vy[CW];
      s2_in.ux    = vx[CW] ? $unsigned(-vx) : $unsigned(vx);
      s2_in.uy    = vy[CW] ? $unsigned(-vy) : $unsigned(vy);
      s2_in.r1    = s1_ff.first_radius;
      s2_in.r2    = s1_ff.second_radius;
      s2_in.rsum  = {1'b0, s1_ff.first_radius} + {1'b0, s1_ff.second_radius};
      s2_in.rdiff = (s1_ff.first_radius > s1_ff.second_radius)
                  ? s1_ff.first_radius - s1_ff.second_radius
                  : s1_ff.second_radius - s1_ff.first_radius;
      s2_in.c1x   = s1_ff.first_center_x;
      s2_in.c1y   = s1_ff.first_center_y;
   end

   always_comb begin
      s3_in.uxsq   = {{UW{1'b0}}, s2_ff.ux} * {{UW{1'b0}}, s2_ff.ux};
      s3_in.uysq   = {{UW{1'b0}}, s2_ff.uy} * {{UW{1'b0}}, s2_ff.uy};
      s3_in.r1sq   = {{RW{1'b0}}, s2_ff.r1} * {{RW{1'b0}}, s2_ff.r1};
      s3_in.r2sq   = {{RW{1'b0}}, s2_ff.r2} * {{RW{1'b0}}, s2_ff.r2};
      s3_in.diffsq = {{RW{1'b0}}, s2_ff.rdiff} * {{RW{1'b0}}, s2_ff.rdiff};
      s3_in.sumsq  = {{(RW+1){1'b0}}, s2_ff.rsum} * {{(RW+1){1'b0}}, s2_ff.rsum};
      s3_in.ux     = s2_ff.ux;
      s3_in.uy     = s2_ff.uy;
      s3_in.xneg   = s2_ff.xneg;
      s3_in.yneg   = s2_ff.yneg;
      s3_in.c1x    = s2_ff.c1x;
      s3_in.c1y    = s2_ff.c1y;
   end

   always_comb begin
      s4_in.d2     = s3_ff.uxsq + s3_ff.uysq;
      s4_in.r1sq   = s3_ff.r1sq;
      s4_in.r2sq   = s3_ff.r2sq;
      s4_in.diffsq = s3_ff.diffsq;
      s4_in.sumsq  = s3_ff.sumsq;
      s4_in.ux     = s3_ff.ux;
      s4_in.uy     = s3_ff.uy;
      s4_in.xneg   = s3_ff.xneg;
      s4_in.yneg   = s3_ff.yneg;
      s4_in.c1x    = s3_ff.c1x;
      s4_in.c1y    = s3_ff.c1y;
   end

   always_comb begin
      if (s4_ff.d2 > {{(SW-2*RW-2){1'b0}}, s4_ff.sumsq}) begin
         s5_in.status = ccin_pkg::STATUS_FAR;
      end else if (s4_ff.d2 < {{(SW-2*RW){1'b0}}, s4_ff.diffsq}) begin
         s5_in.status = ccin_pkg::STATUS_NESTED;
      end else if (s4_ff.d2 == '0) begin
         s5_in.status = ccin_pkg::STATUS_CONCENTRIC;
      end else begin
         s5_in.status = ccin_pkg::STATUS_FOUND;
      end
      s5_in.p    = s4_ff.d2 + {{(SW-2*RW){1'b0}}, s4_ff.r1sq};
      s5_in.r1sq = s4_ff.r1sq;
      s5_in.r2sq = s4_ff.r2sq;
      s5_in.ux   = s4_ff.ux;
      s5_in.uy   = s4_ff.uy;
      s5_in.xneg = s4_ff.xneg;
      s5_in.yneg = s4_ff.yneg;
      s5_in.c1x  = s4_ff.c1x;
      s5_in.c1y  = s4_ff.c1y;
   end

   logic [SW-1:0] r2sq_ext;
   assign r2sq_ext = {{(SW-2*RW){1'b0}}, s5_ff.r2sq};

   always_comb begin
      s6_in.status = s5_ff.status;
      s6_in.aneg   = s5_ff.p < r2sq_ext;
      s6_in.num    = (s5_ff.p < r2sq_ext) ? r2sq_ext - s5_ff.p : s5_ff.p - r2sq_ext;
      s6_in.r1sq   = s5_ff.r1sq;
      s6_in.ux     = s5_ff.ux;
      s6_in.uy     = s5_ff.uy;
      s6_in.xneg   = s5_ff.xneg;
      s6_in.yneg   = s5_ff.yneg;
      s6_in.c1x    = s5_ff.c1x;
      s6_in.c1y    = s5_ff.c1y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_chan.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= req_chan.data;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   // distance
   logic          sq1_vld;
   logic [UW-1:0] sq1_root;

   ccin_sqrt u_sqrt_dist (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s4_vld_ff),
      .radicand  (s4_ff.d2),
      .out_valid (sq1_vld),
      .root      (sq1_root)
   );

   a_type         dl1_ff [L1];
   logic [L1-1:0] dl1_vld_ff;
   a_type         a_cur;
   b_type         b_in;

   assign a_cur = dl1_ff[L1-1];

   always_comb begin
      b_in.status = a_cur.status;
      b_in.aneg   = a_cur.aneg;
      b_in.d      = sq1_root;
      b_in.r1sq   = a_cur.r1sq;
      b_in.ux     = a_cur.ux;
      b_in.uy     = a_cur.uy;
      b_in.xneg   = a_cur.xneg;
      b_in.yneg   = a_cur.yneg;
      b_in.c1x    = a_cur.c1x;
      b_in.c1y    = a_cur.c1y;
   end

   // a = num / 2d
   logic          dva_vld;
   logic [AW-1:0] dva_quo;

   ccin_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (sq1_vld),
      .num       ({{(NW-SW){1'b0}}, a_cur.num}),
      .den       ({sq1_root, 1'b0}),
      .out_valid (dva_vld),
      .quo       (dva_quo)
   );

   b_type         dl2_ff [L2];
   logic [L2-1:0] dl2_vld_ff;

   t1_type t1_ff, t1_in;
   t2_type t2_ff, t2_in;
   logic   t1_vld_ff, t2_vld_ff;

   logic [2*AW-1:0] r1sq_wide;
   logic [2*AW-1:0] hrad;

   always_comb begin
      t1_in.b    = dl2_ff[L2-1];
      t1_in.amag = dva_quo;
      t1_in.hh   = {{AW{1'b0}}, dva_quo} * {{AW{1'b0}}, dva_quo};
   end

   assign r1sq_wide = {{(2*AW-2*RW){1'b0}}, t1_ff.b.r1sq};
   assign hrad      = (r1sq_wide > t1_ff.hh) ? r1sq_wide - t1_ff.hh : '0;

   always_comb begin
      t2_in.b    = t1_ff.b;
      t2_in.amag = t1_ff.amag;
      t2_in.rad  = hrad[SW-1:0];
   end

   // half chord
   logic          sq2_vld;
   logic [UW-1:0] sq2_root;

   ccin_sqrt u_sqrt_chord (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (t2_vld_ff),
      .radicand  (t2_ff.rad),
      .out_valid (sq2_vld),
      .root      (sq2_root)
   );

   c_type         dl3_ff [L3];
   logic [L3-1:0] dl3_vld_ff;
   c_type         c_cur;
   u_type         u1_ff, u1_in;
   logic          u1_vld_ff;

   assign c_cur = dl3_ff[L3-1];

   always_comb begin
      u1_in.e.status = c_cur.b.status;
      u1_in.e.aneg   = c_cur.b.aneg;
      u1_in.e.xneg   = c_cur.b.xneg;
      u1_in.e.yneg   = c_cur.b.yneg;
      u1_in.e.c1x    = c_cur.b.c1x;
      u1_in.e.c1y    = c_cur.b.c1y;
      u1_in.d        = c_cur.b.d;
      u1_in.pax      = {{UW{1'b0}}, c_cur.amag} * {{AW{1'b0}}, c_cur.b.ux};
      u1_in.pay      = {{UW{1'b0}}, c_cur.amag} * {{AW{1'b0}}, c_cur.b.uy};
      u1_in.phx      = {{AW{1'b0}}, sq2_root} * {{AW{1'b0}}, c_cur.b.uy};
      u1_in.phy      = {{AW{1'b0}}, sq2_root} * {{AW{1'b0}}, c_cur.b.ux};
   end

   logic          qax_vld, qay_vld, qhx_vld, qhy_vld;
   logic [AW-1:0] qax, qay, qhx, qhy;
   logic [DW-1:0] den_d;

   assign den_d = {1'b0, u1_ff.d};

   ccin_div u_div_ax (
      .clock (clock), .reset (reset), .enable (adv), .in_valid (u1_vld_ff),
      .num (u1_ff.pax), .den (den_d), .out_valid (qax_vld), .quo (qax)
   );

   ccin_div u_div_ay (
      .clock (clock), .reset (reset), .enable (adv), .in_valid (u1_vld_ff),
      .num (u1_ff.pay), .den (den_d), .out_valid (qay_vld), .quo (qay)
   );

   ccin_div u_div_hx (
      .clock (clock), .reset (reset), .enable (adv), .in_valid (u1_vld_ff),
      .num (u1_ff.phx), .den (den_d), .out_valid (qhx_vld), .quo (qhx)
   );

   ccin_div u_div_hy (
      .clock (clock), .reset (reset), .enable (adv), .in_valid (u1_vld_ff),
      .num (u1_ff.phy), .den (den_d), .out_valid (qhy_vld), .quo (qhy)
   );

   e_type         dl4_ff [L4];
   logic [L4-1:0] dl4_vld_ff;
   e_type         e_cur;
   v_type         v1_ff, v1_in;
   logic          v1_vld_ff;

   logic signed [TW-1:0] c1x_ext, c1y_ext, tax, tay, thx, thy;

   assign e_cur   = dl4_ff[L4-1];
   assign c1x_ext = $signed({{(TW-CW){e_cur.c1x[CW-1]}}, e_cur.c1x});
   assign c1y_ext = $signed({{(TW-CW){e_cur.c1y[CW-1]}}, e_cur.c1y});

   always_comb begin
      tax = $signed({{(TW-AW){1'b0}}, qax});
      tay = $signed({{(TW-AW){1'b0}}, qay});
      thx = $signed({{(TW-AW){1'b0}}, qhx});
      thy = $signed({{(TW-AW){1'b0}}, qhy});
      if (e_cur.aneg ^ e_cur.xneg) tax = -tax;
      if (e_cur.aneg ^ e_cur.yneg) tay = -tay;
      if (e_cur.yneg) thx = -thx;
      if (e_cur.xneg) thy = -thy;
      v1_in.status = e_cur.status;
      v1_in.p1x    = c1x_ext + tax + thx;
      v1_in.p1y    = c1y_ext + tay - thy;
      v1_in.p2x    = c1x_ext + tax - thx;
      v1_in.p2y    = c1y_ext + tay + thy;
   end

   ccin_pkg::rsp_type out_ff, out_in;
   logic              out_vld_ff;

   always_comb begin
      out_in.status = v1_ff.status;
      if (v1_ff.status == ccin_pkg::STATUS_FOUND) begin
         out_in.point_one_x = sat_coord(v1_ff.p1x);
         out_in.point_one_y = sat_coord(v1_ff.p1y);
         out_in.point_two_x = sat_coord(v1_ff.p2x);
         out_in.point_two_y = sat_coord(v1_ff.p2y);
      end else begin
         out_in.point_one_x = '0;
         out_in.point_one_y = '0;
         out_in.point_two_x = '0;
         out_in.point_two_y = '0;
      end
   end

   // back stages and alignment lines
   always_ff @(posedge clock) begin
      if (reset) begin
         dl1_vld_ff <= '0;
         dl2_vld_ff <= '0;
         t1_vld_ff  <= 1'b0;
         t2_vld_ff  <= 1'b0;
         dl3_vld_ff <= '0;
         u1_vld_ff  <= 1'b0;
         dl4_vld_ff <= '0;
         v1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         dl1_vld_ff <= {dl1_vld_ff[L1-2:0], s6_vld_ff};
         dl2_vld_ff <= {dl2_vld_ff[L2-2:0], dl1_vld_ff[L1-1]};
         t1_vld_ff  <= dl2_vld_ff[L2-1];
         t2_vld_ff  <= t1_vld_ff;
         dl3_vld_ff <= {dl3_vld_ff[L3-2:0], t2_vld_ff};
         u1_vld_ff  <= dl3_vld_ff[L3-1];
         dl4_vld_ff <= {dl4_vld_ff[L4-2:0], u1_vld_ff};
         v1_vld_ff  <= dl4_vld_ff[L4-1];
         out_vld_ff <= v1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dl1_ff[0] <= s6_ff;
         for (int k = 1; k < L1; k++) dl1_ff[k] <= dl1_ff[k-1];
         dl2_ff[0] <= b_in;
         for (int k = 1; k < L2; k++) dl2_ff[k] <= dl2_ff[k-1];
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         dl3_ff[0].b    <= t2_ff.b;
         dl3_ff[0].amag <= t2_ff.amag;
         for (int k = 1; k < L3; k++) dl3_ff[k] <= dl3_ff[k-1];
         u1_ff <= u1_in;
         dl4_ff[0] <= u1_ff.e;
         for (int k = 1; k < L4; k++) dl4_ff[k] <= dl4_ff[k-1];
         v1_ff  <= v1_in;
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.data  = out_ff;

`ifndef SYNTH
   a_dist_align : assert property (@(posedge clock) disable iff (reset)
      sq1_vld == dl1_vld_ff[L1-1])
      else $error("distance root out of step with its word");

   a_div_align : assert property (@(posedge clock) disable iff (reset)
      dva_vld == dl2_vld_ff[L2-1])
      else $error("a quotient out of step with its word");

   a_chord_align : assert property (@(posedge clock) disable iff (reset)
      sq2_vld == dl3_vld_ff[L3-1])
      else $error("chord root out of step with its word");

   a_term_align : assert property (@(posedge clock) disable iff (reset)
      dl4_vld_ff[L4-1] == qax_vld && qax_vld == qay_vld &&
      qay_vld == qhx_vld && qhx_vld == qhy_vld)
      else $error("term quotients out of step");

   a_zero_points : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.status != ccin_pkg::STATUS_FOUND |->
      rsp_chan.data.point_one_x == '0 && rsp_chan.data.point_one_y == '0 &&
      rsp_chan.data.point_two_x == '0 && rsp_chan.data.point_two_y == '0)
      else $error("points not zero on a reject status");
`endif

endmodule

/* rtl/ccin_sqrt.sv */
module ccin_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic [ccin_pkg::SW-1:0] radicand,
   output logic                    out_valid,
   output logic [ccin_pkg::UW-1:0] root
);
   localparam int N   = ccin_pkg::UW;
   localparam int SW  = ccin_pkg::SW;
   localparam int RMW = N + 2;

   logic [RMW-1:0] rem_ff  [N];
   logic [N-1:0]   root_ff [N];
   logic [SW-1:0]  rad_ff  [N];
   logic [N-1:0]   vld_ff;

   logic [RMW-1:0] rem_src  [N];
   logic [N-1:0]   root_src [N];
   logic [SW-1:0]  rad_src  [N];
   logic [N-1:0]   vld_src;

   logic [RMW-1:0] rem_in  [N];
   logic [N-1:0]   root_in [N];
   logic [SW-1:0]  rad_in  [N];

   logic [N+2:0]   cand  [N];
   logic [N+2:0]   trial [N];
   logic [N+2:0]   diffv [N];
   logic [N-1:0]   ge;

   assign rem_src[0]  = '0;
   assign root_src[0] = '0;
   assign rad_src[0]  = radicand;
   assign vld_src     = {vld_ff[N-2:0], in_valid};

   for (genvar k = 1; k < N; k++) begin : g_src
      assign rem_src[k]  = rem_ff[k-1];
      assign root_src[k] = root_ff[k-1];
      assign rad_src[k]  = rad_ff[k-1];
   end

   // one root bit per stage
   always_comb begin
      for (int k = 0; k < N; k++) begin
         cand[k]    = {rem_src[k][N:0], rad_src[k][SW-1 -: 2]};
         trial[k]   = {1'b0, root_src[k], 2'b01};
         diffv[k]   = cand[k] - trial[k];
         ge[k]      = cand[k] >= trial[k];
         rem_in[k]  = ge[k] ? diffv[k][RMW-1:0] : cand[k][RMW-1:0];
         root_in[k] = {root_src[k][N-2:0], ge[k]};
         rad_in[k]  = {rad_src[k][SW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_src;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign root      = root_ff[N-1];

endmodule

/* rtl/ccin_div.sv */
module ccin_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic [ccin_pkg::NW-1:0] num,
   input  logic [ccin_pkg::DW-1:0] den,
   output logic                    out_valid,
   output logic [ccin_pkg::AW-1:0] quo
);
   localparam int N  = ccin_pkg::AW;
   localparam int NW = ccin_pkg::NW;
   localparam int DW = ccin_pkg::DW;

   logic [DW-1:0] rem_ff [N];
   logic [N-1:0]  low_ff [N];
   logic [N-1:0]  quo_ff [N];
   logic [DW-1:0] den_ff [N];
   logic [N-1:0]  vld_ff;

   logic [DW-1:0] rem_src [N];
   logic [N-1:0]  low_src [N];
   logic [N-1:0]  quo_src [N];
   logic [DW-1:0] den_src [N];
   logic [N-1:0]  vld_src;

   logic [DW-1:0] rem_in [N];
   logic [N-1:0]  low_in [N];
   logic [N-1:0]  quo_in [N];

   logic [DW:0]   cand  [N];
   logic [DW:0]   diffv [N];
   logic [N-1:0]  ge;

   // high part of the numerator must stay below the divisor; the block itself does not enforce it
   assign rem_src[0] = {{(DW-(NW-N)){1'b0}}, num[NW-1:N]};
   assign low_src[0] = num[N-1:0];
   assign quo_src[0] = '0;
   assign den_src[0] = den;
   assign vld_src    = {vld_ff[N-2:0], in_valid};

   for (genvar k = 1; k < N; k++) begin : g_src
      assign rem_src[k] = rem_ff[k-1];
      assign low_src[k] = low_ff[k-1];
      assign quo_src[k] = quo_ff[k-1];
      assign den_src[k] = den_ff[k-1];
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         cand[k]   = {rem_src[k], low_src[k][N-1]};
         diffv[k]  = cand[k] - {1'b0, den_src[k]};
         ge[k]     = cand[k] >= {1'b0, den_src[k]};
         rem_in[k] = ge[k] ? diffv[k][DW-1:0] : cand[k][DW-1:0];
         low_in[k] = {low_src[k][N-2:0], 1'b0};
         quo_in[k] = {quo_src[k][N-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_src;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_src[k];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign quo       = quo_ff[N-1];

endmodule

/* tb/sv/circle_circle_intersection_unit_test.sv */
`timescale 1ns / 1ps

module circle_circle_intersection_unit_test;

   localparam int LATENCY = 143;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PAIRS = 700;
   localparam int CW = ccin_pkg::CW;
   localparam int REQ_BITS = $bits(ccin_pkg::req_type);
   localparam logic [127:0] TERM_CAP = 128'd1 << 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ccin_req_if req_chan ();
   ccin_rsp_if rsp_chan ();

   circle_circle_intersection_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #10 clock = ~clock;

   ccin_pkg::rsp_type expected_points[$];
   int errors = 0;
   int pairs_sent = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_done = 1'b0;

   typedef struct {
      ccin_pkg::req_type pair;
      bit                typed;
      ccin_pkg::rsp_type want;
   } pair_row_type;

   function automatic logic [63:0] isqrt(logic [127:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if ({64'd0, trial} * {64'd0, trial} <= x) root = trial;
      end
      return root;
   endfunction

   function automatic logic [127:0] capped_quotient(logic [127:0] n, logic [127:0] d);
      logic [127:0] q;
      q = n / d;
      return (q > TERM_CAP) ? TERM_CAP : q;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[CW-1:0];
   endfunction

   function automatic ccin_pkg::rsp_type intersect_circles(ccin_pkg::req_type p);
      ccin_pkg::rsp_type r;
      longint c1x, c1y, c2x, c2y, vx, vy, ax, ay, hx, hy;
      logic [127:0] ux, uy, r1, r2, d2, r1sq, r2sq, sum, dif, d, pp, num, amag, h, hh;
      bit aneg, xneg, yneg;
      c1x = longint'(p.first_center_x);
      c1y = longint'(p.first_center_y);
      c2x = longint'(p.second_center_x);
      c2y = longint'(p.second_center_y);
      r1 = 128'(p.first_radius);
      r2 = 128'(p.second_radius);
      vx = c2x - c1x;
      vy = c2y - c1y;
      xneg = vx < 0;
      yneg = vy < 0;
      ux = 128'(xneg ? -vx : vx);
      uy = 128'(yneg ? -vy : vy);
      d2 = ux * ux + uy * uy;
      r1sq = r1 * r1;
      r2sq = r2 * r2;
      sum = r1 + r2;
      dif = (r1 > r2) ? r1 - r2 : r2 - r1;
      r = '0;
      if (d2 > sum * sum) begin
         r.status = ccin_pkg::STATUS_FAR;
         return r;
      end
      if (d2 < dif * dif) begin
         r.status = ccin_pkg::STATUS_NESTED;
         return r;
      end
      if (d2 == 0) begin
         r.status = ccin_pkg::STATUS_CONCENTRIC;
         return r;
      end
      d = 128'(isqrt(d2));
      pp = r1sq + d2;
      aneg = pp < r2sq;
      num = aneg ? r2sq - pp : pp - r2sq;
      amag = capped_quotient(num, 2 * d);
      hh = amag * amag;
      h = (r1sq > hh) ? 128'(isqrt(r1sq - hh)) : '0;
      ax = longint'(capped_quotient(amag * ux, d));
      ay = longint'(capped_quotient(amag * uy, d));
      hx = longint'(capped_quotient(h * uy, d));
      hy = longint'(capped_quotient(h * ux, d));
      if (aneg != xneg) ax = -ax;
      if (aneg != yneg) ay = -ay;
      if (yneg) hx = -hx;
      if (xneg) hy = -hy;
      r.status = ccin_pkg::STATUS_FOUND;
      r.point_one_x = clamp_coord(c1x + ax + hx);
      r.point_one_y = clamp_coord(c1y + ay - hy);
      r.point_two_x = clamp_coord(c1x + ax - hx);
      r.point_two_y = clamp_coord(c1y + ay + hy);
      return r;
   endfunction

   // result side: compare every accepted word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_points.size() == 0) begin
            $error("result word with no expectation pending");
            errors++;
         end else begin
            ccin_pkg::rsp_type e;
            ccin_pkg::rsp_type a;
            e = expected_points.pop_front();
            a = rsp_chan.data;
            if (a.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, a.status);
               errors++;
            end
            if (a.point_one_x !== e.point_one_x) begin
               $error("point_one_x: expected %0d, got %0d", e.point_one_x, a.point_one_x);
               errors++;
            end
            if (a.point_one_y !== e.point_one_y) begin
               $error("point_one_y: expected %0d, got %0d", e.point_one_y, a.point_one_y);
               errors++;
            end
            if (a.point_two_x !== e.point_two_x) begin
               $error("point_two_x: expected %0d, got %0d", e.point_two_x, a.point_two_x);
               errors++;
            end
            if (a.point_two_y !== e.point_two_y) begin
               $error("point_two_y: expected %0d, got %0d", e.point_two_y, a.point_two_y);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random stalls, one long hold once 200 pairs have been sent
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && pairs_sent >= 200) begin
            hold++;
            rsp_chan.ready <= 1'b0;
            if (hold >= 400) hold_done = 1'b1;
         end else begin
            rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= 8);
         end
      end
   end

   task automatic send_pair(ccin_pkg::req_type p, bit typed, ccin_pkg::rsp_type want);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < 8) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= p;
      do @(posedge clock); while (!req_chan.ready);
      expected_points = {expected_points, (typed ? want : intersect_circles(p))};
      pairs_sent++;
      @(negedge clock);
   endtask

   function automatic ccin_pkg::req_type make_pair(int cx, int cy, int r1, int c2, int dx,
                                                   int dy, int r2);
      ccin_pkg::req_type p;
      p.first_center_x = cx;
      p.first_center_y = cy;
      p.first_radius = 31'(r1);
      p.second_center_x = c2 ? dx : cx + dx;
      p.second_center_y = c2 ? dy : cy + dy;
      p.second_radius = 31'(r2);
      return p;
   endfunction

   function automatic ccin_pkg::req_type random_pair();
      ccin_pkg::req_type p;
      int k;
      int dx;
      int dy;
      int r1;
      longint span;
      k = $urandom_range(2, 30);
      if ($urandom_range(0, 9) == 0) begin
         p = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         return p;
      end
      dx = int'($urandom) >>> (31 - k);
      dy = int'($urandom) >>> (31 - k);
      span = longint'($sqrt(real'(dx) * dx + real'(dy) * dy));
      r1 = $urandom_range(0, (1 << k) < 0 ? 32'h7fffffff : (1 << k));
      p.first_center_x = $urandom;
      p.first_center_y = $urandom;
      if ($urandom_range(0, 3) == 0) p.first_center_x = int'(p.first_center_x) >>> 8;
      p.first_radius = 31'(r1);
      p.second_center_x = p.first_center_x + dx;
      p.second_center_y = p.first_center_y + dy;
      case ($urandom_range(0, 3))
         0: p.second_radius = 31'($urandom_range(0, 32'h7fffffff) >> (31 - k));
         1: p.second_radius = 31'(((span > r1) ? span - r1 : r1 - span) +
                                  $urandom_range(0, 3));
         default: p.second_radius = 31'(((span > r1) ? span - r1 : r1 - span) +
                                        $urandom_range(0, 2 * r1 + 1));
      endcase
      return p;
   endfunction

   initial begin
      pair_row_type rows[$];
      pair_row_type row;
      ccin_pkg::rsp_type far_pts;
      ccin_pkg::rsp_type nested_pts;
      ccin_pkg::rsp_type concentric_pts;
      far_pts = '0;
      far_pts.status = ccin_pkg::STATUS_FAR;
      nested_pts = '0;
      nested_pts.status = ccin_pkg::STATUS_NESTED;
      concentric_pts = '0;
      concentric_pts.status = ccin_pkg::STATUS_CONCENTRIC;

      req_chan.valid = 1'b0;
      req_chan.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      rows = '{
         '{make_pair(0, 0, 32'h10000, 0, 32'h640000, 0, 32'h10000), 1, far_pts},
         '{make_pair(0, 0, 32'h100000, 0, 32'h10000, 0, 32'h10000), 1, nested_pts},
         '{make_pair(5, 7, 32'h10000, 0, 0, 0, 32'h10000), 1, concentric_pts},
         '{make_pair(0, 0, 0, 0, 0, 0, 0), 1, concentric_pts},
         '{make_pair(-5, 9, 32'h7fffffff, 0, 0, 0, 32'h7fffffff), 1, concentric_pts},
         '{make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 1, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff), 1, far_pts},
         '{make_pair(32'h80000000, 32'h80000000, 0, 1, 32'h7fffffff,
                     32'h7fffffff, 0), 1, far_pts},
         '{make_pair(0, 0, 32'h7fffffff, 0, 1, 0, 0), 1, nested_pts},
         '{make_pair(0, 0, 32'h30000, 0, 32'h40000, 0, 32'h30000), 0, '0},
         '{make_pair(0, 0, 32'h30000, 0, 32'h60000, 0, 32'h30000), 0, '0},
         '{make_pair(0, 0, 32'h50000, 0, 32'h30000, 32'h40000, 32'h50000), 0, '0},
         '{make_pair(0, 0, 32'h50000, 0, -32'h30000, -32'h40000, 32'h20000), 0, '0},
         '{make_pair(0, 0, 32'h20000, 0, 32'h10000, 0, 32'h10000), 0, '0},
         '{make_pair(32'h7fff0000, 32'h7fff0000, 32'h7fffffff, 0, 32'h10000, 0,
                     32'h7fffffff), 0, '0},
         '{make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 32'h10000, 0,
                     32'h7fffffff), 0, '0},
         '{make_pair(32'h80000000, 0, 32'h7fffffff, 1, 32'h7fffffff, 0,
                     32'h7fffffff), 0, '0},
         '{make_pair(0, 0, 1, 0, 1, 1, 1), 0, '0},
         '{make_pair(0, 0, 32'h7fffffff, 0, 32'h7fffffff, 0, 1), 0, '0},
         '{make_pair(100, -100, 32'h55555555, 0, -32'h2aaaaaaa, 32'h15555555,
                     32'h2aaaaaaa), 0, '0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_pair(row.pair, row.typed, row.want);
      end

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         quiet = (n >= 300 && n < 420);
         if (n == 500) begin
            req_chan.valid <= 1'b0;
            wait (expected_points.size() == 0);
            @(negedge clock);
         end
         send_pair(random_pair(), 0, '0);
      end
      quiet = 1'b0;
      req_chan.valid <= 1'b0;

      wait (expected_points.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
